[hw/rtl/assert_macros.svh]
// Assertion macros shared by the sprite line evaluation RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define SPE_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check that a condition never holds outside reset.
`define SPE_NEVER(label, clk, rst, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);

`endif

[hw/rtl/spe_pkg.sv]
// Shared types and constants for the sprite line evaluation block.
package spe_pkg;

   localparam int TABLE_BYTES = 256;
   localparam int TABLE_AW    = 8;
   localparam int FOUND_W     = 4;
   localparam int SLOT_W      = 3;
   localparam int PAT_W       = 13;
   localparam int ATTR_W      = 6;
   localparam int PEND_W      = 20;

   // Dot boundaries of the scanline phases.
   localparam logic [8:0] EVAL_START = 9'd64;
   localparam logic [8:0] READ_START = 9'd256;
   localparam logic [8:0] LATE_START = 9'd320;

   localparam logic [7:0] FILL_BYTE   = 8'hFF;
   localparam logic [7:0] SHADOW_ADDR = 8'd252;
   localparam logic [7:0] ENTRY_MASK  = 8'hFC;

   localparam logic [8:0] SHORT_HEIGHT = 9'd8;
   localparam logic [8:0] TALL_HEIGHT  = 9'd16;

   typedef enum logic [1:0] {
      OP_TICK,
      OP_SET_ADDR,
      OP_WRITE,
      OP_CLEAR_OVF
   } op_type;

   typedef enum logic [2:0] {
      PH_COMPARE,
      PH_COPY1,
      PH_COPY2,
      PH_COPY3,
      PH_IDLE,
      PH_BUGGED
   } phase_type;

   // Sprite table access issued by the evaluation stage.
   typedef struct packed {
      logic                wr_en;
      logic [TABLE_AW-1:0] wr_addr;
      logic [7:0]          wr_data;
      logic                rd_en;
      logic [TABLE_AW-1:0] rd_addr;
   } prim_req_type;

   typedef struct packed {
      logic [7:0]        bus_byte;
      logic              overflow_flag;
      logic [FOUND_W-1:0] found_count;
      logic              record_done;
      logic [SLOT_W-1:0] record_slot;
      logic [7:0]        record_x;
      logic [PAT_W-1:0]  record_pattern_address;
      logic [ATTR_W-1:0] record_attributes;
      logic              record_hflip;
   } eval_result_type;

endpackage

[hw/rtl/sprite_line_evaluation.sv]
// Requests enter the input stage; the evaluated result is registered in the result stage.
// Throughput: one request per clock while the result is not stalled; the single evaluation
// stage and the registered read of the 256-byte sprite table RAM set this rate.
// A stalled result holds the evaluation stage; one more request may wait in the input stage.
// Reset (synchronous, active high) clears all control state, the valid bits of the sprite
// table (it reads as zero until written) and fills the secondary table with 0xFF at once.
`include "assert_macros.svh"

module sprite_line_evaluation import spe_pkg::*; #(
   parameter int SPRITES_PER_LINE = 8
) (
   input  logic                clock,
   input  logic                reset,
   // configuration port
   input  logic                csr_write_enable,
   input  logic                csr_index,
   input  logic                csr_write_data,
   // request channel
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [1:0]          req_operation,
   input  logic [8:0]          req_dot,
   input  logic [7:0]          req_scanline,
   input  logic [7:0]          req_data_byte,
   // result channel
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [7:0]          rsp_bus_byte,
   output logic                rsp_overflow_flag,
   output logic [FOUND_W-1:0]  rsp_found_count,
   output logic                rsp_record_done,
   output logic [SLOT_W-1:0]   rsp_record_slot,
   output logic [7:0]          rsp_record_x,
   output logic [PAT_W-1:0]    rsp_record_pattern_address,
   output logic [ATTR_W-1:0]   rsp_record_attributes,
   output logic                rsp_record_hflip
);

   // Configuration register indexes.
   localparam logic CSR_TALL_SPRITES = 1'b0;
   localparam logic CSR_TABLE_HIGH   = 1'b1;

   logic            tall_ff, tall_in;
   logic            table_high_ff, table_high_in;

   // Input stage.
   logic            s1_valid_ff, s1_valid_in;
   logic [1:0]      s1_op_ff;
   logic [8:0]      s1_dot_ff;
   logic [7:0]      s1_scanline_ff;
   logic [7:0]      s1_data_ff;

   // Result stage.
   logic            rsp_valid_ff, rsp_valid_in;
   eval_result_type rsp_data_ff;

   logic            advance;
   logic            load;
   eval_result_type result;
   prim_req_type    prim_req;
   logic [7:0]      prim_byte;
   logic [7:0]      shadow_byte;

   // Evaluate the held request whenever the result register is free or draining.
   assign advance   = s1_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = s1_valid_ff && !advance;
   assign load      = req_valid && !req_stall;

   always_comb begin
      tall_in       = tall_ff;
      table_high_in = table_high_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            CSR_TALL_SPRITES: tall_in       = csr_write_data;
            CSR_TABLE_HIGH:   table_high_in = csr_write_data;
         endcase
      end
   end

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (load) begin
         s1_valid_in = 1'b1;
      end else if (advance) begin
         s1_valid_in = 1'b0;
      end
      // Hold a stalled result, drop it once taken.
      rsp_valid_in = advance || (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tall_ff       <= 1'b0;
         table_high_ff <= 1'b0;
         s1_valid_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         tall_ff       <= tall_in;
         table_high_ff <= table_high_in;
         s1_valid_ff   <= s1_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      if (load) begin
         s1_op_ff       <= req_operation;
         s1_dot_ff      <= req_dot;
         s1_scanline_ff <= req_scanline;
         s1_data_ff     <= req_data_byte;
      end
      if (advance) begin
         rsp_data_ff <= result;
      end
   end

   // Sprite table; its read is issued as a request enters the input stage.
   spe_primary u_primary (
      .clock      (clock),
      .reset      (reset),
      .req        (prim_req),
      .rd_byte    (prim_byte),
      .shadow_byte(shadow_byte)
   );

   spe_eval #(
      .SPRITES_PER_LINE(SPRITES_PER_LINE)
   ) u_eval (
      .clock           (clock),
      .reset           (reset),
      .advance         (advance),
      .item_op         (s1_op_ff),
      .item_dot        (s1_dot_ff),
      .item_scanline   (s1_scanline_ff),
      .item_data       (s1_data_ff),
      .load            (load),
      .load_op         (req_operation),
      .load_dot        (req_dot),
      .tall_sprites    (tall_ff),
      .small_table_high(table_high_ff),
      .prim_byte       (prim_byte),
      .shadow_byte     (shadow_byte),
      .prim_req        (prim_req),
      .result          (result)
   );

   assign rsp_valid                  = rsp_valid_ff;
   assign rsp_bus_byte               = rsp_data_ff.bus_byte;
   assign rsp_overflow_flag          = rsp_data_ff.overflow_flag;
   assign rsp_found_count            = rsp_data_ff.found_count;
   assign rsp_record_done            = rsp_data_ff.record_done;
   assign rsp_record_slot            = rsp_data_ff.record_slot;
   assign rsp_record_x               = rsp_data_ff.record_x;
   assign rsp_record_pattern_address = rsp_data_ff.record_pattern_address;
   assign rsp_record_attributes      = rsp_data_ff.record_attributes;
   assign rsp_record_hflip           = rsp_data_ff.record_hflip;

   `SPE_ASSERT(a_advance_fills_result, clock, reset,
      advance |=> rsp_valid_ff,
      "evaluated request did not reach the result register")
   `SPE_ASSERT(a_stall_needs_held, clock, reset,
      req_stall |-> (s1_valid_ff && rsp_valid_ff),
      "request stalled with a free input or result stage")

endmodule

[hw/rtl/spe_ram.sv]
// Generic single-port-write, registered-read RAM.
module spe_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[hw/rtl/spe_primary.sv]
// Primary sprite table: RAM, per-byte valid bits, write bypass and entry 252 shadow.
`include "assert_macros.svh"

module spe_primary import spe_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  prim_req_type req,
   output logic [7:0]   rd_byte,
   output logic [7:0]   shadow_byte
);

   logic [7:0]             ram_q;
   logic [TABLE_BYTES-1:0] valid_ff;
   logic [TABLE_BYTES-1:0] valid_in;
   logic                   hit_ff;
   logic                   hit_in;
   logic                   rd_valid_ff;
   logic                   rd_valid_in;
   logic [7:0]             bypass_ff;
   logic [7:0]             bypass_in;
   logic [7:0]             shadow_ff;
   logic [7:0]             shadow_in;

   spe_ram #(
      .WIDTH(8),
      .DEPTH(TABLE_BYTES)
   ) u_ram (
      .clock  (clock),
      .wr_en  (req.wr_en),
      .wr_addr(req.wr_addr),
      .wr_data(req.wr_data),
      .rd_en  (req.rd_en),
      .rd_addr(req.rd_addr),
      .rd_data(ram_q)
   );

   always_comb begin
      valid_in    = valid_ff;
      hit_in      = hit_ff;
      rd_valid_in = rd_valid_ff;
      bypass_in   = bypass_ff;
      shadow_in   = shadow_ff;
      if (req.wr_en) begin
         valid_in[req.wr_addr] = 1'b1;
         if (req.wr_addr == SHADOW_ADDR) begin
            shadow_in = req.wr_data;
         end
      end
      // Capture read-during-write so the new byte wins over the RAM output.
      if (req.rd_en) begin
         hit_in      = req.wr_en && (req.wr_addr == req.rd_addr);
         rd_valid_in = valid_ff[req.rd_addr];
         bypass_in   = req.wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         hit_ff      <= 1'b0;
         rd_valid_ff <= 1'b0;
         shadow_ff   <= '0;
      end else begin
         valid_ff    <= valid_in;
         hit_ff      <= hit_in;
         rd_valid_ff <= rd_valid_in;
         shadow_ff   <= shadow_in;
      end
      bypass_ff <= bypass_in;
   end

   assign rd_byte     = hit_ff ? bypass_ff : (rd_valid_ff ? ram_q : 8'h00);
   assign shadow_byte = shadow_ff;

   `SPE_ASSERT(a_write_bypass, clock, reset,
      (req.wr_en && req.rd_en && req.wr_addr == req.rd_addr) |=> hit_ff,
      "read of a byte written on the same edge did not take the bypass")

endmodule

[hw/rtl/spe_eval.sv]
// Per-dot sprite evaluation: state machine, secondary table and record builder.
`include "assert_macros.svh"

module spe_eval import spe_pkg::*; #(
   parameter int SPRITES_PER_LINE = 8
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            advance,
   input  logic [1:0]      item_op,
   input  logic [8:0]      item_dot,
   input  logic [7:0]      item_scanline,
   input  logic [7:0]      item_data,
   input  logic            load,
   input  logic [1:0]      load_op,
   input  logic [8:0]      load_dot,
   input  logic            tall_sprites,
   input  logic            small_table_high,
   input  logic [7:0]      prim_byte,
   input  logic [7:0]      shadow_byte,
   output prim_req_type    prim_req,
   output eval_result_type result
);

   localparam int SEC_BYTES = SPRITES_PER_LINE * 4;
   localparam int SEC_W     = $clog2(SEC_BYTES);
   localparam int SF_W      = $clog2(SPRITES_PER_LINE + 1);

   logic [7:0]      ta_ff, ta_in;
   logic [7:0]      sp_ff, sp_in;
   logic [5:0]      cp_ff, cp_in;
   logic [SF_W-1:0] sf_ff, sf_in;
   logic [7:0]      bus_ff, bus_in;
   logic            ovf_ff, ovf_in;
   logic [3:0]      row_ff, row_in;
   logic            zero_ff, zero_in;
   logic [PEND_W-1:0] pend_ff, pend_in;
   phase_type       phase_ff, phase_in;
   logic [7:0]      sec_ff [SEC_BYTES];

   op_type          op;
   logic            tick;
   logic            zone_clear, zone_eval, zone_read;
   logic            line_start, odd_eval;
   logic            full;
   logic [9:0]      diff;
   logic            in_range;
   logic [7:0]      sp_plus1, sp_plus4, sp_diag;
   logic [SF_W-1:0] sf_plus1;
   logic            clear_ok;
   logic [4:0]      rb_idx;
   logic [7:0]      readback_byte, late_byte;
   logic [3:0]      prow;
   logic [PAT_W-1:0] pat;
   logic [PEND_W-1:0] rec_pend;
   logic            push;
   logic            sec_we;
   logic [SEC_W-1:0] sec_idx;
   logic [7:0]      sec_wd;
   logic            rec_done;

   assign op         = op_type'(item_op);
   assign tick       = advance && (op == OP_TICK);
   assign zone_clear = item_dot < EVAL_START;
   assign zone_eval  = !zone_clear && (item_dot < READ_START);
   assign zone_read  = (item_dot >= READ_START) && (item_dot < LATE_START);
   assign line_start = tick && (item_dot == EVAL_START);
   assign odd_eval   = tick && zone_eval && item_dot[0];
   assign full       = sf_ff >= SF_W'(SPRITES_PER_LINE);

   // Signed row of the sprite on this line; in range when 0 <= row < height.
   assign diff     = {2'b00, item_scanline} - {2'b00, prim_byte} - 10'd1;
   assign in_range = !diff[9] && (diff[8:0] < (tall_sprites ? TALL_HEIGHT : SHORT_HEIGHT));

   assign sp_plus1 = sp_ff + 8'd1;
   assign sp_plus4 = sp_ff + 8'd4;
   assign sp_diag  = {sp_plus4[7:2], sp_plus1[1:0]};
   assign sf_plus1 = sf_ff + 1'b1;

   assign clear_ok      = {2'b00, item_dot[5:1]} < 7'(SEC_BYTES);
   assign rb_idx        = {item_dot[5:3], item_dot[2] ? 2'b11 : item_dot[1:0]};
   assign readback_byte = ({2'b00, rb_idx} < 7'(SEC_BYTES)) ? sec_ff[SEC_W'(rb_idx)] : FILL_BYTE;
   assign late_byte     = (sf_ff == '0) ? shadow_byte : sec_ff[0];

   // Pattern row address; prim_byte holds the attribute byte on this dot.
   assign prow = tall_sprites ? (prim_byte[7] ? ~row_ff : row_ff)
                              : {1'b0, prim_byte[7] ? ~row_ff[2:0] : row_ff[2:0]};
   assign pat  = tall_sprites ? {pend_ff[0], pend_ff[7:1], prow[3], 1'b0, prow[2:0]}
                              : {small_table_high, pend_ff[7:0], prow};
   assign rec_pend = {prim_byte[6], prim_byte[5], zero_ff, prim_byte[1:0], 2'b00, pat};

   // Next phase.
   always_comb begin
      phase_in = phase_ff;
      if (line_start) begin
         phase_in = PH_COMPARE;
      end else if (odd_eval) begin
         unique case (phase_ff)
            PH_COMPARE: begin
               if (in_range) begin
                  phase_in = PH_COPY1;
               end else if (sp_plus4 == 8'd0) begin
                  phase_in = PH_IDLE;
               end
            end
            PH_COPY1: phase_in = PH_COPY2;
            PH_COPY2: phase_in = PH_COPY3;
            PH_COPY3: begin
               priority if (full) begin
                  phase_in = PH_BUGGED;
               end else if (sp_plus1 == 8'd0) begin
                  phase_in = PH_IDLE;
               end else if (sf_plus1 < SF_W'(SPRITES_PER_LINE)) begin
                  phase_in = PH_COMPARE;
               end else begin
                  phase_in = PH_BUGGED;
               end
            end
            PH_BUGGED: begin
               if (in_range) begin
                  phase_in = PH_COPY1;
               end else if (sp_diag < 8'd4) begin
                  phase_in = PH_IDLE;
               end
            end
            default: phase_in = PH_IDLE;
         endcase
      end
   end

   // Datapath and outputs.
   always_comb begin
      ta_in    = ta_ff;
      sp_in    = sp_ff;
      cp_in    = cp_ff;
      sf_in    = sf_ff;
      bus_in   = bus_ff;
      ovf_in   = ovf_ff;
      row_in   = row_ff;
      zero_in  = zero_ff;
      pend_in  = pend_ff;
      push     = 1'b0;
      sec_we   = 1'b0;
      sec_idx  = '0;
      sec_wd   = prim_byte;
      rec_done = 1'b0;
      if (advance) begin
         unique case (op)
            OP_TICK: begin
               priority if (zone_clear) begin
                  bus_in  = FILL_BYTE;
                  sec_we  = clear_ok;
                  sec_idx = SEC_W'(item_dot[5:1]);
                  sec_wd  = FILL_BYTE;
               end else if (zone_eval) begin
                  bus_in = prim_byte;
                  if (!item_dot[0]) begin
                     if (line_start) begin
                        sf_in = '0;
                        sp_in = '0;
                        cp_in = '0;
                     end
                  end else begin
                     unique case (phase_ff)
                        PH_COMPARE: begin
                           if (!in_range) begin
                              sp_in = sp_plus4;
                           end else begin
                              push    = 1'b1;
                              zero_in = (sp_ff == (ta_ff & ENTRY_MASK));
                              row_in  = diff[3:0];
                              sp_in   = sp_plus1;
                           end
                        end
                        PH_COPY1, PH_COPY2, PH_COPY3: begin
                           sp_in = sp_plus1;
                           if (!full) begin
                              push = 1'b1;
                              priority if (phase_ff == PH_COPY1) begin
                                 pend_in = PEND_W'(prim_byte);
                              end else if (phase_ff == PH_COPY2) begin
                                 pend_in = rec_pend;
                              end else begin
                                 rec_done = 1'b1;
                                 sf_in    = sf_plus1;
                              end
                           end
                        end
                        PH_BUGGED: begin
                           if (!in_range) begin
                              sp_in = sp_diag;
                           end else begin
                              sp_in  = sp_plus1;
                              ovf_in = 1'b1;
                           end
                        end
                        default: sp_in = sp_plus4;
                     endcase
                  end
               end else if (zone_read) begin
                  bus_in = readback_byte;
               end else begin
                  bus_in = late_byte;
               end
            end
            OP_SET_ADDR:  ta_in  = item_data;
            OP_WRITE:     ta_in  = ta_ff + 8'd1;
            OP_CLEAR_OVF: ovf_in = 1'b0;
         endcase
      end
      // Copy into the secondary table; drop writes past its end.
      if (push) begin
         sec_we  = {1'b0, cp_ff} < 7'(SEC_BYTES);
         sec_idx = cp_ff[SEC_W-1:0];
         cp_in   = cp_ff + 6'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ta_ff    <= '0;
         sp_ff    <= '0;
         cp_ff    <= '0;
         sf_ff    <= '0;
         bus_ff   <= '0;
         ovf_ff   <= 1'b0;
         row_ff   <= '0;
         zero_ff  <= 1'b0;
         pend_ff  <= '0;
         phase_ff <= PH_COMPARE;
         for (int i = 0; i < SEC_BYTES; i++) begin
            sec_ff[i] <= FILL_BYTE;
         end
      end else begin
         ta_ff    <= ta_in;
         sp_ff    <= sp_in;
         cp_ff    <= cp_in;
         sf_ff    <= sf_in;
         bus_ff   <= bus_in;
         ovf_ff   <= ovf_in;
         row_ff   <= row_in;
         zero_ff  <= zero_in;
         pend_ff  <= pend_in;
         phase_ff <= phase_in;
         if (sec_we) begin
            sec_ff[sec_idx] <= sec_wd;
         end
      end
   end

   assign prim_req.wr_en   = advance && (op == OP_WRITE);
   assign prim_req.wr_addr = ta_ff;
   assign prim_req.wr_data = item_data;
   assign prim_req.rd_en   = load;
   assign prim_req.rd_addr = ((op_type'(load_op) == OP_TICK) && (load_dot == EVAL_START))
                             ? 8'd0 : sp_in;

   assign result.bus_byte               = bus_in;
   assign result.overflow_flag          = ovf_in;
   assign result.found_count            = FOUND_W'(sf_in);
   assign result.record_done            = rec_done;
   assign result.record_slot            = rec_done ? SLOT_W'(sf_ff) : '0;
   assign result.record_x               = rec_done ? prim_byte : '0;
   assign result.record_pattern_address = rec_done ? pend_ff[PAT_W-1:0] : '0;
   assign result.record_attributes      = rec_done ? pend_ff[PAT_W+ATTR_W-1:PAT_W] : '0;
   assign result.record_hflip           = rec_done ? pend_ff[PEND_W-1] : 1'b0;

   `SPE_NEVER(a_found_bound, clock, reset,
      sf_ff > SF_W'(SPRITES_PER_LINE),
      "sprite count passed the per-line limit")
   `SPE_ASSERT(a_record_phase, clock, reset,
      rec_done |-> (phase_ff == PH_COPY3 && !full && advance),
      "record reported outside the last copy step")

endmodule
